// ===== rtl/core/bts_pkg.sv =====
`default_nettype none

package bts_pkg;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_PLAY  = 2'd1;
	localparam logic [1:0] KIND_SEG   = 2'd2;
	localparam logic [1:0] KIND_START = 2'd3;

	localparam logic [1:0] PWM_NONE  = 2'd0;
	localparam logic [1:0] PWM_START = 2'd1;
	localparam logic [1:0] PWM_STOP  = 2'd2;

	localparam logic [7:0] ENDLESS      = 8'hFF;
	localparam logic [3:0] PROT_DEFAULT = 4'd6;

	typedef struct packed {
		logic [7:0]  on_t;
		logic [7:0]  off_t;
		logic [6:0]  duty;
		logic [15:0] freq;
	} seg_t;

	localparam int SEG_W = $bits(seg_t);

	// one repeat used up; endless and exhausted counts stay put
	function automatic logic [7:0] count_repeat(input logic [7:0] r);
		return (r != ENDLESS && r != 8'd0) ? r - 8'd1 : r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bts_ram.sv =====
`default_nettype none

module bts_ram #(
	parameter int WIDTH = 39,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/buzzer_tone_pattern_sequencer_core.sv =====
// Buzzer tone pattern sequencer.
// Input channel item_valid/item_ready carries one item: a tick, a play request,
// a segment memory write or a pattern start table write. Every accepted item
// gives exactly one result on res_valid/res_ready: accepted flag, PWM command
// (none, start, stop) with duty and frequency, and busy.
// Writes, refused or idle plays and non-expiring ticks give their result with
// no memory read; a play of a nonzero pattern first reads the start table; a
// tick that expires the count waits on a chain of dependent reads: current
// segment, next segment, start table, restart segment. Items that need no read
// follow each other every cycle while the receiver takes each result.
// The result sits in an output register, so a new item is taken in the cycle
// the previous result transfers; while the receiver stalls, at most one result
// waits and further items are held off.
// cfg_we writes the protected pattern number at once (reset value 6).
// Reset clears the sequencer registers and res_valid but not the result fields;
// the segment memory and start table are not cleared and must be loaded before
// any pattern that uses them is played.
`default_nettype none

module buzzer_tone_pattern_sequencer_core import bts_pkg::*; #(
	parameter int SEGMENT_DEPTH = 32,
	parameter int PATTERN_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  pattern,
	input  wire logic [7:0]  repeat_count,
	input  wire logic [4:0]  entry_index,
	input  wire logic [7:0]  seg_on_time,
	input  wire logic [7:0]  seg_off_time,
	input  wire logic [6:0]  seg_duty,
	input  wire logic [15:0] seg_freq,
	input  wire logic [4:0]  pattern_start,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic             accepted,
	output logic [1:0]       pwm_action,
	output logic [6:0]       pwm_duty,
	output logic [15:0]      pwm_freq,
	output logic             busy_res
);

	localparam int AW    = $clog2(SEGMENT_DEPTH);
	localparam int PW    = $clog2(PATTERN_COUNT);
	localparam int PTR_W = (AW > 5) ? AW : 5;
	localparam int SX_W  = (PW > 4) ? PW : 4;
	localparam logic [PTR_W:0] SEG_LIM = (PTR_W+1)'(SEGMENT_DEPTH);
	localparam logic [SX_W:0]  PAT_LIM = (SX_W+1)'(PATTERN_COUNT);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PLAY  = 3'd1;
	localparam logic [2:0] ST_SOUND = 3'd2;
	localparam logic [2:0] ST_CUR   = 3'd3;
	localparam logic [2:0] ST_NEXT  = 3'd4;
	localparam logic [2:0] ST_RST   = 3'd5;

	logic [2:0]       st_q, st_d;
	logic [7:0]       tick_q, tick_d;
	logic             tone_q, tone_d;
	logic [3:0]       act_q, act_d;
	logic [7:0]       rep_q, rep_d;
	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic [3:0]       prot_q;
	logic             seg_ok_q, st_ok_q;

	logic             acc;
	logic             emit, e_acc;
	logic [1:0]       e_act;
	logic [6:0]       e_duty;
	logic [15:0]      e_freq;
	logic             e_busy;

	logic             seg_we, seg_re, st_we, st_re;
	logic [PTR_W-1:0] seg_ra_full, idx_full;
	logic [SX_W-1:0]  st_ra_full, slot_full;
	logic             seg_rd_ok, st_rd_ok, idx_ok, slot_ok;
	logic [SEG_W-1:0] seg_rdata;
	logic [4:0]       st_rdata;
	seg_t             seg, seg_wr;
	logic [4:0]       st_val;
	logic [PTR_W:0]   ptr_inc;
	logic [PTR_W-1:0] ptr_wrap;
	logic [7:0]       rep_c;

	assign item_ready = (st_q == ST_IDLE) && (!res_valid || res_ready);
	assign acc        = item_valid && item_ready;

	assign idx_full  = PTR_W'(entry_index);
	assign idx_ok    = {1'b0, idx_full} < SEG_LIM;
	assign slot_full = SX_W'(pattern);
	assign slot_ok   = {1'b0, slot_full} < PAT_LIM;
	assign seg_rd_ok = {1'b0, seg_ra_full} < SEG_LIM;
	assign st_rd_ok  = {1'b0, st_ra_full} < PAT_LIM;

	assign seg_wr = '{on_t: seg_on_time, off_t: seg_off_time, duty: seg_duty, freq: seg_freq};

	// out-of-range reads return a terminator segment and start address 0
	assign seg    = seg_ok_q ? seg_t'(seg_rdata) : '0;
	assign st_val = st_ok_q ? st_rdata : 5'd0;

	assign ptr_inc  = {1'b0, ptr_q} + (PTR_W+1)'(1);
	assign ptr_wrap = (ptr_inc >= SEG_LIM) ? '0 : ptr_inc[PTR_W-1:0];
	assign rep_c    = count_repeat(rep_q);

	always_comb begin
		st_d        = st_q;
		tick_d      = tick_q;
		tone_d      = tone_q;
		act_d       = act_q;
		rep_d       = rep_q;
		ptr_d       = ptr_q;
		emit        = 1'b0;
		e_acc       = 1'b1;
		e_act       = PWM_NONE;
		e_duty      = '0;
		e_freq      = '0;
		seg_we      = 1'b0;
		st_we       = 1'b0;
		seg_re      = 1'b0;
		st_re       = 1'b0;
		seg_ra_full = ptr_q;
		st_ra_full  = slot_full;
		unique case (st_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (kind)
						KIND_TICK: begin
							if (tick_q == 8'd0) begin
								emit = 1'b1;
							end else if (tick_q != 8'd1) begin
								tick_d = tick_q - 8'd1;
								emit   = 1'b1;
							end else begin
								// count expires: fetch the current segment
								tick_d = 8'd0;
								seg_re = 1'b1;
								st_d   = tone_q ? ST_CUR : ST_SOUND;
							end
						end
						KIND_PLAY: begin
							if (tick_q != 8'd0 && act_q == prot_q) begin
								emit  = 1'b1;
								e_acc = 1'b0;
							end else begin
								tone_d = 1'b0;
								tick_d = 8'd0;
								if (pattern != 4'd0) begin
									tick_d = 8'd1;
									act_d  = pattern;
									rep_d  = repeat_count;
									st_re  = 1'b1;
									st_d   = ST_PLAY;
								end else begin
									emit = 1'b1;
								end
							end
						end
						KIND_SEG: begin
							seg_we = idx_ok;
							emit   = 1'b1;
						end
						KIND_START: begin
							st_we = slot_ok;
							emit  = 1'b1;
						end
					endcase
				end
			end
			ST_PLAY: begin
				ptr_d = PTR_W'(st_val);
				emit  = 1'b1;
				st_d  = ST_IDLE;
			end
			ST_SOUND: begin
				tone_d = 1'b1;
				tick_d = seg.on_t;
				emit   = 1'b1;
				e_act  = PWM_START;
				e_duty = seg.duty;
				e_freq = seg.freq;
				st_d   = ST_IDLE;
			end
			ST_CUR: begin
				if (seg.off_t != 8'd0) begin
					tone_d = 1'b0;
					rep_d  = rep_c;
					tick_d = (rep_c != 8'd0) ? seg.off_t : 8'd0;
					emit   = 1'b1;
					e_act  = PWM_STOP;
					st_d   = ST_IDLE;
				end else begin
					// chained segment: advance and fetch the next one
					ptr_d       = ptr_wrap;
					seg_re      = 1'b1;
					seg_ra_full = ptr_wrap;
					st_d        = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (seg.on_t != 8'd0) begin
					tone_d = 1'b1;
					tick_d = seg.on_t;
					emit   = 1'b1;
					e_act  = PWM_START;
					e_duty = seg.duty;
					e_freq = seg.freq;
					st_d   = ST_IDLE;
				end else if (seg.off_t == 8'd0 && rep_c != 8'd0) begin
					// terminator with repeats left: restart from the pattern start
					rep_d      = rep_c;
					st_re      = 1'b1;
					st_ra_full = SX_W'(act_q);
					st_d       = ST_RST;
				end else begin
					tone_d = 1'b0;
					rep_d  = rep_c;
					tick_d = (rep_c != 8'd0) ? seg.off_t : 8'd0;
					emit   = 1'b1;
					e_act  = PWM_STOP;
					st_d   = ST_IDLE;
				end
			end
			ST_RST: begin
				ptr_d       = PTR_W'(st_val);
				seg_re      = 1'b1;
				seg_ra_full = PTR_W'(st_val);
				st_d        = ST_SOUND;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
		e_busy = (rep_d != 8'd0) || (tick_d != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			tick_q    <= 8'd0;
			tone_q    <= 1'b0;
			act_q     <= 4'd0;
			rep_q     <= 8'd0;
			ptr_q     <= '0;
			prot_q    <= PROT_DEFAULT;
			res_valid <= 1'b0;
		end else begin
			st_q      <= st_d;
			tick_q    <= tick_d;
			tone_q    <= tone_d;
			act_q     <= act_d;
			rep_q     <= rep_d;
			ptr_q     <= ptr_d;
			res_valid <= emit || (res_valid && !res_ready);
			if (cfg_we) begin
				prot_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seg_re) begin
			seg_ok_q <= seg_rd_ok;
		end
		if (st_re) begin
			st_ok_q <= st_rd_ok;
		end
		if (emit) begin
			accepted   <= e_acc;
			pwm_action <= e_act;
			pwm_duty   <= e_duty;
			pwm_freq   <= e_freq;
			busy_res   <= e_busy;
		end
	end

	bts_ram #(
		.WIDTH(SEG_W),
		.DEPTH(SEGMENT_DEPTH)
	) u_seg_mem (
		.clk   (clk),
		.we    (seg_we),
		.waddr (idx_full[AW-1:0]),
		.wdata (seg_wr),
		.re    (seg_re),
		.raddr (seg_ra_full[AW-1:0]),
		.rdata (seg_rdata)
	);

	bts_ram #(
		.WIDTH(5),
		.DEPTH(PATTERN_COUNT)
	) u_start_mem (
		.clk   (clk),
		.we    (st_we),
		.waddr (slot_full[PW-1:0]),
		.wdata (pattern_start),
		.re    (st_re),
		.raddr (st_ra_full[PW-1:0]),
		.rdata (st_rdata)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!res_valid || res_ready))
		else $error("result register overwritten before transfer");

	a_tone_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tone_q) |-> (res_valid && pwm_action == PWM_START))
		else $error("tone turned on without a start command");

	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && kind == KIND_PLAY && tick_q != 8'd0 && act_q == prot_q)
		|=> ($stable(tick_q) && $stable(rep_q) && $stable(ptr_q) && !accepted))
		else $error("refused play changed sequencer state");

	a_read_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		seg_re |=> (st_q == ST_SOUND || st_q == ST_CUR || st_q == ST_NEXT))
		else $error("segment read issued with no state to consume it");

	a_sound_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SOUND) |=> (st_q == ST_IDLE))
		else $error("sound step did not return to idle");

endmodule

`default_nettype wire
